FILE: rtl/lhp_pkg.sv
// Shared types, constants and helper functions for the latency histogram block.
// Used by lhp_div, lhp_ctrl, lhp_dp and latency_histogram_percentile.
package lhp_pkg;

   localparam int NUM_BUCKETS    = 64;
   localparam int COUNTER_BITS   = 32;
   localparam int BUCKET_BITS    = (NUM_BUCKETS > 2) ? $clog2(NUM_BUCKETS) : 1;
   localparam int STEP_BITS      = (BUCKET_BITS > 1) ? $clog2(BUCKET_BITS) : 1;

   localparam int LAT_BITS       = 20;
   localparam int IDX_BITS       = 6;
   localparam int PERMILLE_BITS  = 10;
   localparam int WIDTH_BITS     = 16;
   localparam int PVAL_BITS      = 23;
   localparam int OUT_BITS       = 32;

   localparam int PERMILLE_SCALE = 1000;
   localparam int SCALE_BITS     = 10;
   localparam int PROD_BITS      = COUNTER_BITS + PERMILLE_BITS;
   localparam int SUM_BITS       = COUNTER_BITS + BUCKET_BITS + SCALE_BITS;
   localparam int EDGE_BITS      = BUCKET_BITS + 1 + WIDTH_BITS;
   localparam int CMP_BITS       = LAT_BITS + WIDTH_BITS + BUCKET_BITS;

   localparam int REQ_DATA_BITS  = 40;
   localparam int MODE_BITS      = 2;
   localparam int RSP_DATA_BITS  = 88;
   localparam int RSP_USED_BITS  = PVAL_BITS + 2 * OUT_BITS;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 23;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BUCKET_WIDTH   = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OVERFLOW_VALUE = 1'b1;

   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET    = 16'd1;
   localparam logic [PVAL_BITS-1:0]  OVERFLOW_RESET = 23'd4194304;
   localparam logic [PVAL_BITS-1:0]  PVAL_MAX       = '1;
   localparam logic [OUT_BITS-1:0]   OUT_MAX        = '1;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_RECORD = 2'd0,
      MODE_QUERY  = 2'd1,
      MODE_READ   = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic rec_rd;
      logic rec_wr;
      logic q_init;
      logic walk_rd;
      logic scale;
      logic acc;
      logic walk_inc;
      logic edge_ld;
      logic ovf_ld;
      logic idx_rd;
      logic bval_ld;
      logic clear;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic total_zero;
      logic hit;
      logic walk_last;
   } dp_status_type;

   function automatic logic [OUT_BITS-1:0] sat_out(input logic [COUNTER_BITS-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return (w > 64'(OUT_MAX)) ? OUT_MAX : OUT_BITS'(w);
   endfunction

endpackage

FILE: rtl/lhp_div.sv
// Restoring divider for the bucket index: latency / width, clamped to the last bucket.
// One quotient bit per cycle; depends on lhp_pkg.
module lhp_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [lhp_pkg::LAT_BITS-1:0]     dividend,
   input  logic [lhp_pkg::WIDTH_BITS-1:0]   divisor,
   output logic                             busy,
   output logic [lhp_pkg::BUCKET_BITS-1:0]  quotient
);

   localparam logic [lhp_pkg::BUCKET_BITS-1:0] LAST = lhp_pkg::BUCKET_BITS'(lhp_pkg::NUM_BUCKETS - 1);

   logic                              busy_ff, busy_in;
   logic [lhp_pkg::LAT_BITS-1:0]      rem_ff, rem_in;
   logic [lhp_pkg::BUCKET_BITS-1:0]   q_ff, q_in;
   logic [lhp_pkg::STEP_BITS-1:0]     step_ff, step_in;
   logic [lhp_pkg::CMP_BITS-1:0]      limit;
   logic [lhp_pkg::CMP_BITS-1:0]      trial;
   logic                              fits;

   assign limit = lhp_pkg::CMP_BITS'(divisor) << lhp_pkg::BUCKET_BITS;
   assign trial = lhp_pkg::CMP_BITS'(divisor) << step_ff;
   assign fits  = lhp_pkg::CMP_BITS'(rem_ff) >= trial;

   always_comb begin
      busy_in = busy_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      step_in = step_ff;
      if (start) begin
         if (lhp_pkg::CMP_BITS'(dividend) >= limit) begin
            q_in    = '1;
            busy_in = 1'b0;
         end else begin
            rem_in  = dividend;
            q_in    = '0;
            step_in = lhp_pkg::STEP_BITS'(lhp_pkg::BUCKET_BITS - 1);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - lhp_pkg::LAT_BITS'(trial);
            q_in   = q_ff | (lhp_pkg::BUCKET_BITS'(1) << step_ff);
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff - lhp_pkg::STEP_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      step_ff <= step_in;
   end

   assign busy     = busy_ff;
   assign quotient = (q_ff > LAST) ? LAST : q_ff;

endmodule

FILE: rtl/lhp_ctrl.sv
// Controller state machine for the latency histogram block.
// Sequences the datapath by commands and owns the result valid flag; depends on lhp_pkg.
module lhp_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [lhp_pkg::MODE_BITS-1:0] req_mode,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  lhp_pkg::dp_status_type        status,
   output lhp_pkg::dp_cmd_type           cmd
);

   typedef enum logic [14:0] {
      S_IDLE      = 15'b000000000000001,
      S_REC_START = 15'b000000000000010,
      S_REC_DIV   = 15'b000000000000100,
      S_REC_RD    = 15'b000000000001000,
      S_REC_WR    = 15'b000000000010000,
      S_Q_MUL     = 15'b000000000100000,
      S_Q_RD      = 15'b000000001000000,
      S_Q_SCALE   = 15'b000000010000000,
      S_Q_ACC     = 15'b000000100000000,
      S_Q_EDGE    = 15'b000001000000000,
      S_Q_OVF     = 15'b000010000000000,
      S_B_RD      = 15'b000100000000000,
      S_B_LD      = 15'b001000000000000,
      S_CLR       = 15'b010000000000000,
      S_FIN       = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               case (lhp_pkg::mode_type'(req_mode))
                  lhp_pkg::MODE_RECORD: state_in = S_REC_START;
                  lhp_pkg::MODE_QUERY:  state_in = S_Q_MUL;
                  lhp_pkg::MODE_READ:   state_in = S_B_RD;
                  lhp_pkg::MODE_CLEAR:  state_in = S_CLR;
                  default:              state_in = S_CLR;
               endcase
            end
         end
         S_REC_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_REC_DIV;
         end
         S_REC_DIV: begin
            if (!status.div_busy) begin
               state_in = S_REC_RD;
            end
         end
         S_REC_RD: begin
            cmd.rec_rd = 1'b1;
            state_in   = S_REC_WR;
         end
         S_REC_WR: begin
            cmd.rec_wr = 1'b1;
            state_in   = S_FIN;
         end
         S_Q_MUL: begin
            cmd.q_init = 1'b1;
            state_in   = status.total_zero ? S_FIN : S_Q_RD;
         end
         S_Q_RD: begin
            cmd.walk_rd = 1'b1;
            state_in    = S_Q_SCALE;
         end
         S_Q_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_Q_ACC;
         end
         S_Q_ACC: begin
            cmd.acc = 1'b1;
            if (status.hit) begin
               state_in = S_Q_EDGE;
            end else if (status.walk_last) begin
               state_in = S_Q_OVF;
            end else begin
               cmd.walk_inc = 1'b1;
               state_in     = S_Q_RD;
            end
         end
         S_Q_EDGE: begin
            cmd.edge_ld = 1'b1;
            state_in    = S_FIN;
         end
         S_Q_OVF: begin
            cmd.ovf_ld = 1'b1;
            state_in   = S_FIN;
         end
         S_B_RD: begin
            cmd.idx_rd = 1'b1;
            state_in   = S_B_LD;
         end
         S_B_LD: begin
            cmd.bval_ld = 1'b1;
            state_in    = S_FIN;
         end
         S_CLR: begin
            cmd.clear = 1'b1;
            state_in  = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: rtl/lhp_dp.sv
// Datapath for the latency histogram block: counter memory, total, query walk and result register.
// Depends on lhp_pkg and lhp_div.
module lhp_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  lhp_pkg::dp_cmd_type                 cmd,
   output lhp_pkg::dp_status_type              status,
   input  logic [lhp_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic                                csr_wr_en,
   input  logic [lhp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lhp_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output logic [lhp_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);

   localparam int LB = lhp_pkg::LAT_BITS;
   localparam int IB = lhp_pkg::IDX_BITS;
   localparam int PB = lhp_pkg::PERMILLE_BITS;
   localparam int BB = lhp_pkg::BUCKET_BITS;
   localparam int CB = lhp_pkg::COUNTER_BITS;
   localparam int SB = lhp_pkg::SUM_BITS;
   localparam int EB = lhp_pkg::EDGE_BITS;

   logic [lhp_pkg::WIDTH_BITS-1:0]     width_ff, width_in;
   logic [lhp_pkg::PVAL_BITS-1:0]      ovf_ff, ovf_in;
   logic [LB-1:0]                      lat_ff, lat_in;
   logic [IB-1:0]                      idx_ff, idx_in;
   logic [PB-1:0]                      pm_ff, pm_in;
   logic [CB-1:0]                      total_ff, total_in;
   logic [BB-1:0]                      walk_ff, walk_in;
   logic [BB-1:0]                      addr_ff, addr_in;
   logic [lhp_pkg::PROD_BITS-1:0]      prod_ff, prod_in;
   logic [SB-1:0]                      scaled_ff, scaled_in;
   logic [SB-1:0]                      acc_ff, acc_in;
   logic                               oob_ff, oob_in;
   logic [lhp_pkg::PVAL_BITS-1:0]      pval_ff, pval_in;
   logic [lhp_pkg::OUT_BITS-1:0]       bval_ff, bval_in;
   logic [lhp_pkg::RSP_DATA_BITS-1:0]  rsp_data_ff, rsp_data_in;
   logic [lhp_pkg::NUM_BUCKETS-1:0]    valid_ff, valid_in;
   logic [CB-1:0]                      rdata_ff;
   logic                               rvalid_ff;
   logic [CB-1:0]                      count_mem_ff [lhp_pkg::NUM_BUCKETS];

   logic [lhp_pkg::WIDTH_BITS-1:0]     eff_w;
   logic                               div_busy;
   logic [BB-1:0]                      quot;
   logic [BB-1:0]                      raddr;
   logic                               mem_re;
   logic [CB-1:0]                      cnt;
   logic [CB-1:0]                      cnt_inc;
   logic [CB-1:0]                      total_inc;
   logic [SB-1:0]                      acc_sum;
   logic [EB-1:0]                      edge_val;

   assign eff_w = (width_ff == '0) ? lhp_pkg::WIDTH_BITS'(1) : width_ff;

   lhp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (lat_ff),
      .divisor  (eff_w),
      .busy     (div_busy),
      .quotient (quot)
   );

   always_comb begin
      if (cmd.rec_rd) begin
         raddr = quot;
      end else if (cmd.walk_rd) begin
         raddr = walk_ff;
      end else begin
         raddr = BB'(idx_ff);
      end
   end

   assign mem_re    = cmd.rec_rd || cmd.walk_rd || cmd.idx_rd;
   assign cnt       = rvalid_ff ? rdata_ff : '0;
   assign cnt_inc   = (cnt == '1) ? cnt : cnt + CB'(1);
   assign total_inc = (total_ff == '1) ? total_ff : total_ff + CB'(1);
   assign acc_sum   = acc_ff + scaled_ff;
   assign edge_val  = (EB'(walk_ff) + EB'(1)) * EB'(eff_w);

   always_comb begin
      width_in = width_ff;
      ovf_in   = ovf_ff;
      if (csr_wr_en && csr_index == lhp_pkg::CSR_BUCKET_WIDTH) begin
         width_in = lhp_pkg::WIDTH_BITS'(csr_wdata);
      end
      if (csr_wr_en && csr_index == lhp_pkg::CSR_OVERFLOW_VALUE) begin
         ovf_in = csr_wdata;
      end
   end

   always_comb begin
      lat_in      = cmd.load ? req_tdata[LB-1:0] : lat_ff;
      idx_in      = cmd.load ? req_tdata[LB +: IB] : idx_ff;
      pm_in       = cmd.load ? req_tdata[LB+IB +: PB] : pm_ff;
      addr_in     = cmd.rec_rd ? quot : addr_ff;
      prod_in     = cmd.q_init ? lhp_pkg::PROD_BITS'(total_ff) * lhp_pkg::PROD_BITS'(pm_ff)
                               : prod_ff;
      scaled_in   = cmd.scale ? SB'(cnt) * SB'(lhp_pkg::PERMILLE_SCALE) : scaled_ff;
      oob_in      = cmd.idx_rd ? !(32'(idx_ff) < lhp_pkg::NUM_BUCKETS) : oob_ff;

      total_in = total_ff;
      if (cmd.clear) begin
         total_in = '0;
      end else if (cmd.rec_wr) begin
         total_in = total_inc;
      end

      walk_in = walk_ff;
      acc_in  = acc_ff;
      if (cmd.q_init) begin
         walk_in = '0;
         acc_in  = '0;
      end else begin
         if (cmd.acc) begin
            acc_in = acc_sum;
         end
         if (cmd.walk_inc) begin
            walk_in = walk_ff + BB'(1);
         end
      end

      pval_in = pval_ff;
      if (cmd.load) begin
         pval_in = '0;
      end else if (cmd.edge_ld) begin
         pval_in = (64'(edge_val) > 64'(lhp_pkg::PVAL_MAX)) ? lhp_pkg::PVAL_MAX
                                                           : lhp_pkg::PVAL_BITS'(edge_val);
      end else if (cmd.ovf_ld) begin
         pval_in = ovf_ff;
      end

      bval_in = bval_ff;
      if (cmd.load) begin
         bval_in = '0;
      end else if (cmd.bval_ld) begin
         bval_in = oob_ff ? '0 : lhp_pkg::sat_out(cnt);
      end

      rsp_data_in = rsp_data_ff;
      if (cmd.out_load) begin
         rsp_data_in = lhp_pkg::RSP_DATA_BITS'({lhp_pkg::sat_out(total_ff), bval_ff, pval_ff});
      end

      valid_in = valid_ff;
      if (cmd.clear) begin
         valid_in = '0;
      end else if (cmd.rec_wr) begin
         valid_in[addr_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= lhp_pkg::WIDTH_RESET;
         ovf_ff   <= lhp_pkg::OVERFLOW_RESET;
         total_ff <= '0;
         valid_ff <= '0;
      end else begin
         width_ff <= width_in;
         ovf_ff   <= ovf_in;
         total_ff <= total_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lat_ff      <= lat_in;
      idx_ff      <= idx_in;
      pm_ff       <= pm_in;
      addr_ff     <= addr_in;
      prod_ff     <= prod_in;
      scaled_ff   <= scaled_in;
      acc_ff      <= acc_in;
      walk_ff     <= walk_in;
      oob_ff      <= oob_in;
      pval_ff     <= pval_in;
      bval_ff     <= bval_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.rec_wr) begin
         count_mem_ff[addr_ff] <= cnt_inc;
      end
      if (mem_re) begin
         rdata_ff  <= count_mem_ff[raddr];
         rvalid_ff <= valid_ff[raddr];
      end
   end

   assign status.div_busy   = div_busy;
   assign status.total_zero = (total_ff == '0);
   assign status.hit        = (acc_sum >= SB'(prod_ff));
   assign status.walk_last  = (walk_ff == BB'(lhp_pkg::NUM_BUCKETS - 1));

   assign rsp_tdata = rsp_data_ff;

endmodule

FILE: rtl/latency_histogram_percentile.sv
// Latency histogram with percentile query, one item at a time. Accept to rsp_tvalid: a
// record runs the bit-serial divider, which it skips when the quotient clamps to the last
// bucket; a query ends without a walk when empty, else walks the buckets in turn until the
// percentile is reached or the last bucket is passed. The next item can be taken in the
// cycle in which the result appears, even while it waits. Synchronous reset clears all
// counters at once through per-bucket valid flags. Depends on lhp_pkg, lhp_ctrl and lhp_dp.
module latency_histogram_percentile (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // latency [19:0], bucket_index [25:20], percentile_permille [35:26], zero pad
   input  logic [lhp_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // mode [1:0]
   input  logic [lhp_pkg::MODE_BITS-1:0]       req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // percentile_value [22:0], bucket_value [54:23], total_samples [86:55], zero pad
   output logic [lhp_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [lhp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lhp_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   lhp_pkg::dp_cmd_type    cmd;
   lhp_pkg::dp_status_type status;

   lhp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lhp_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule
